/* src/uart_tty_echo_tx_buffer_core_defines.svh */
`ifndef UART_TTY_ECHO_TX_BUFFER_CORE_DEFINES_SVH
`define UART_TTY_ECHO_TX_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define UTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define UTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/ute_pkg.sv */
package ute_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int PADDR_W    = 3;

    localparam logic [1:0] KIND_RX_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TX_READY = 2'd1;
    localparam logic [1:0] KIND_SW_WRITE = 2'd2;
    localparam logic [1:0] KIND_SW_READ  = 2'd3;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_ECHO = 2'd1;
    localparam logic [1:0] SRC_TX   = 2'd2;
    localparam logic [1:0] SRC_RX   = 2'd3;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       write_accepted;
        logic       tx_irq_on;
        logic       wakeup;
        logic       rx_dropped;
        logic       echo_dropped;
    } t_result;

    typedef struct packed {
        logic       accept;
        logic       read_phase;
    } t_dp_cmd;

    typedef struct packed {
        logic       out_busy;
    } t_dp_status;

endpackage

/* src/ute_in_if.sv */
interface ute_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

/* src/ute_out_if.sv */
interface ute_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       tx_irq_on;
    logic       wakeup;
    logic       rx_dropped;
    logic       echo_dropped;

    modport source (
        output valid, output tx_valid, output tx_byte, output read_valid,
        output read_byte, output write_accepted, output tx_irq_on,
        output wakeup, output rx_dropped, output echo_dropped, input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input read_valid,
        input read_byte, input write_accepted, input tx_irq_on,
        input wakeup, input rx_dropped, input echo_dropped, output ready
    );
endinterface

/* src/ute_ram.sv */
module ute_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ute_ctrl.sv */
module ute_ctrl import ute_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_kind,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // hold off the input while in reset
    assign o_in_ready = i_rst_n && (r_state == ST_IDLE) && !i_status.out_busy;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // pops wait in ST_READ for the store read data
                if (accept && (i_kind == KIND_TX_READY || i_kind == KIND_SW_READ)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept     = accept;
    assign o_cmd.read_phase = (r_state == ST_READ);
endmodule

/* src/ute_dp.sv */
module ute_dp import ute_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_out_ready,
    output logic       o_echo_en,
    output logic       o_out_valid,
    output t_result    o_result,
    output t_dp_status o_status
);
    logic [PTR_W-1:0] r_rx_head, r_rx_tail, r_echo_head, r_echo_tail;
    logic [PTR_W-1:0] r_tx_head, r_tx_tail;
    logic [CNT_W-1:0] r_rx_fill, r_echo_fill, r_tx_fill;
    logic [PTR_W-1:0] n_rx_head, n_rx_tail, n_echo_head, n_echo_tail;
    logic [PTR_W-1:0] n_tx_head, n_tx_tail;
    logic [CNT_W-1:0] n_rx_fill, n_echo_fill, n_tx_fill;
    logic             r_irq, n_irq;
    logic             r_echo_en;
    logic [1:0]       r_src, n_src;
    logic             r_out_valid;
    t_result          r_res;
    t_result          push_res;
    t_result          pop_res;

    logic rx_we, echo_we, tx_we;
    logic rx_re, echo_re, tx_re;
    logic [7:0] rx_rdata, echo_rdata, tx_rdata;
    logic rx_room, echo_room, tx_room;
    logic load_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rx_room   = (r_rx_fill != CNT_W'(FIFO_DEPTH));
    assign echo_room = (r_echo_fill != CNT_W'(FIFO_DEPTH));
    assign tx_room   = (r_tx_fill != CNT_W'(FIFO_DEPTH));

    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_fill   = r_rx_fill;
        n_echo_head = r_echo_head;
        n_echo_tail = r_echo_tail;
        n_echo_fill = r_echo_fill;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_fill   = r_tx_fill;
        n_irq       = r_irq;
        n_src       = SRC_NONE;
        rx_we   = 1'b0;
        echo_we = 1'b0;
        tx_we   = 1'b0;
        rx_re   = 1'b0;
        echo_re = 1'b0;
        tx_re   = 1'b0;
        push_res = '0;
        if (i_cmd.accept) begin
            unique case (i_kind)
                KIND_RX_CHAR: begin
                    rx_we = rx_room;
                    push_res.rx_dropped = !rx_room;
                    if (rx_room) begin
                        n_rx_tail = ptr_inc(r_rx_tail);
                        n_rx_fill = r_rx_fill + 1'b1;
                    end
                    if (r_echo_en) begin
                        echo_we = echo_room;
                        push_res.echo_dropped = !echo_room;
                        if (echo_room) begin
                            n_echo_tail = ptr_inc(r_echo_tail);
                            n_echo_fill = r_echo_fill + 1'b1;
                        end
                        // echo queue going from empty to one entry
                        if (r_echo_fill == '0) begin
                            n_irq = 1'b1;
                        end
                    end
                end
                KIND_TX_READY: begin
                    if (r_echo_fill != '0) begin
                        echo_re     = 1'b1;
                        n_src       = SRC_ECHO;
                        n_echo_head = ptr_inc(r_echo_head);
                        n_echo_fill = r_echo_fill - 1'b1;
                    end else if (r_tx_fill != '0) begin
                        tx_re     = 1'b1;
                        n_src     = SRC_TX;
                        n_tx_head = ptr_inc(r_tx_head);
                        n_tx_fill = r_tx_fill - 1'b1;
                    end else begin
                        n_irq = 1'b0;
                    end
                end
                KIND_SW_WRITE: begin
                    tx_we = tx_room;
                    push_res.write_accepted = tx_room;
                    if (tx_room) begin
                        n_tx_tail = ptr_inc(r_tx_tail);
                        n_tx_fill = r_tx_fill + 1'b1;
                    end
                    n_irq = 1'b1;
                end
                KIND_SW_READ: begin
                    if (r_rx_fill != '0) begin
                        rx_re     = 1'b1;
                        n_src     = SRC_RX;
                        n_rx_head = ptr_inc(r_rx_head);
                        n_rx_fill = r_rx_fill - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        push_res.tx_irq_on = n_irq;
    end

    assign load_push = i_cmd.accept &&
                       (i_kind == KIND_RX_CHAR || i_kind == KIND_SW_WRITE);

    always_comb begin
        pop_res            = '0;
        pop_res.tx_irq_on  = r_irq;
        pop_res.tx_valid   = (r_src == SRC_ECHO) || (r_src == SRC_TX);
        pop_res.wakeup     = (r_src == SRC_TX);
        pop_res.read_valid = (r_src == SRC_RX);
        unique case (r_src)
            SRC_ECHO: pop_res.tx_byte   = echo_rdata;
            SRC_TX:   pop_res.tx_byte   = tx_rdata;
            SRC_RX:   pop_res.read_byte = rx_rdata;
            default: begin
            end
        endcase
    end

    ute_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (i_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    ute_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_echo_ram (
        .i_clk   (i_clk),
        .i_we    (echo_we),
        .i_waddr (r_echo_tail),
        .i_wdata (i_byte),
        .i_re    (echo_re),
        .i_raddr (r_echo_head),
        .o_rdata (echo_rdata)
    );

    ute_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (i_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_echo_head <= '0;
            r_echo_tail <= '0;
            r_echo_fill <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_irq       <= 1'b0;
            r_echo_en   <= 1'b1;
            r_src       <= SRC_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_fill   <= n_rx_fill;
            r_echo_head <= n_echo_head;
            r_echo_tail <= n_echo_tail;
            r_echo_fill <= n_echo_fill;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_fill   <= n_tx_fill;
            r_irq       <= n_irq;
            r_src       <= n_src;
            if (i_cfg_we) begin
                r_echo_en <= i_cfg_data;
            end
            if (load_push || i_cmd.read_phase) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_push) begin
            r_res <= push_res;
        end else if (i_cmd.read_phase) begin
            r_res <= pop_res;
        end
    end

    assign o_echo_en         = r_echo_en;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_res;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
endmodule

/* src/uart_tty_echo_tx_buffer_core.sv */
// TTY echo / transmit buffering core.
// i_in carries one event item per handshake: kind (received char, transmitter
// ready, software write, software read) and in_byte. o_out returns exactly one
// result item per event: the byte sent to the transmitter, the byte read by
// software, write acceptance, the transmit interrupt enable after the event,
// wakeup and the receive/echo drop flags.
// The APB port holds echo_enable at byte address 0; write it only while idle.
// A received char or software write loads its result straight into the output
// register; a transmitter ready or software read first passes through the
// registered read port of a FIFO store and then into the output register.
// Throughput: one push item per cycle while the output is not stalled; i_in is
// not ready during the store read of a pop, so a pop holds off the next item.
// Reset (synchronous, active low) empties all three FIFOs, clears the transmit
// interrupt enable and sets echo_enable to 1. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register and i_in
// stays not ready until that result is taken or is being taken.
module uart_tty_echo_tx_buffer_core import ute_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ute_in_if.sink             i_in,
    ute_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    result;
    logic       echo_en;
    logic       cfg_we;
    logic       in_ready;
    logic       out_valid;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
    assign prdata = (paddr[PADDR_W-1] == 1'b0) ? {31'd0, echo_en} : 32'd0;

    ute_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ute_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_in.kind),
        .i_byte      (i_in.in_byte),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (pwdata[0]),
        .i_out_ready (o_out.ready),
        .o_echo_en   (echo_en),
        .o_out_valid (out_valid),
        .o_result    (result),
        .o_status    (status)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.tx_valid       = result.tx_valid;
    assign o_out.tx_byte        = result.tx_byte;
    assign o_out.read_valid     = result.read_valid;
    assign o_out.read_byte      = result.read_byte;
    assign o_out.write_accepted = result.write_accepted;
    assign o_out.tx_irq_on      = result.tx_irq_on;
    assign o_out.wakeup         = result.wakeup;
    assign o_out.rx_dropped     = result.rx_dropped;
    assign o_out.echo_dropped   = result.echo_dropped;

`include "uart_tty_echo_tx_buffer_core_defines.svh"

    `UTE_ASSERT_NOW(a_stall_blocks_input, o_out.valid && !o_out.ready, !i_in.ready, "input taken while result stalled")
    `UTE_ASSERT_NOW(a_wakeup_needs_tx, o_out.valid && o_out.wakeup, o_out.tx_valid, "wakeup without a sent byte")
    `UTE_ASSERT_NOW(a_idle_bytes_zero, o_out.valid && !o_out.tx_valid && !o_out.read_valid, (o_out.tx_byte == 8'd0) && (o_out.read_byte == 8'd0), "byte field set without its valid flag")
    `UTE_ASSERT_NEXT(a_pop_takes_two, i_in.valid && i_in.ready && i_in.kind[0], !i_in.ready, "next item taken during store read")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ute_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int IDLE_PCT    = 37;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 90;
    localparam int HOLD_AT     = 450;
    localparam int PHASE_ITEMS = 275;

    // register index 0: echo_enable
    localparam logic [PADDR_W-1:0] ECHO_ENABLE_ADDR = PADDR_W'(0 * 4);

    class tty_buffer_tracker;
        logic [7:0] rx_fifo[$];
        logic [7:0] echo_fifo[$];
        logic [7:0] tx_fifo[$];
        bit         irq_en;
        bit         echo_on;
        t_result    pending[$];
        int         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            rx_fifo.delete();
            echo_fifo.delete();
            tx_fifo.delete();
            pending.delete();
            irq_en  = 1'b0;
            echo_on = 1'b1;
        endfunction

        function void set_echo(bit en);
            echo_on = en;
        endfunction

        // work out the reply to one accepted event and queue it
        function void take_event(logic [1:0] kind, logic [7:0] value);
            t_result r;
            r = '0;
            case (kind)
                KIND_RX_CHAR: begin
                    if (rx_fifo.size() < FIFO_DEPTH) rx_fifo.push_back(value);
                    else r.rx_dropped = 1'b1;
                    if (echo_on) begin
                        if (echo_fifo.size() < FIFO_DEPTH) echo_fifo.push_back(value);
                        else r.echo_dropped = 1'b1;
                        if (echo_fifo.size() == 1) irq_en = 1'b1;
                    end
                end
                KIND_TX_READY: begin
                    if (echo_fifo.size() != 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = echo_fifo.pop_front();
                    end else if (tx_fifo.size() != 0) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_fifo.pop_front();
                        r.wakeup   = 1'b1;
                    end else begin
                        irq_en = 1'b0;
                    end
                end
                KIND_SW_WRITE: begin
                    if (tx_fifo.size() < FIFO_DEPTH) begin
                        tx_fifo.push_back(value);
                        r.write_accepted = 1'b1;
                    end
                    irq_en = 1'b1;
                end
                KIND_SW_READ: begin
                    if (rx_fifo.size() != 0) begin
                        r.read_valid = 1'b1;
                        r.read_byte  = rx_fifo.pop_front();
                    end
                end
                default: ;
            endcase
            r.tx_irq_on = irq_en;
            pending.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void match_reply(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected reply %p, expected nothing", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("tx_valid",       want.tx_valid,       got.tx_valid);
            compare_field("tx_byte",        want.tx_byte,        got.tx_byte);
            compare_field("read_valid",     want.read_valid,     got.read_valid);
            compare_field("read_byte",      want.read_byte,      got.read_byte);
            compare_field("write_accepted", want.write_accepted, got.write_accepted);
            compare_field("tx_irq_on",      want.tx_irq_on,      got.tx_irq_on);
            compare_field("wakeup",         want.wakeup,         got.wakeup);
            compare_field("rx_dropped",     want.rx_dropped,     got.rx_dropped);
            compare_field("echo_dropped",   want.echo_dropped,   got.echo_dropped);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    ute_in_if  in_ch ();
    ute_out_if out_ch ();

    tty_buffer_tracker tracker;
    int                items_sent;
    int                cycle_count;
    bit                burst;
    bit                rx_hold;

    uart_tty_echo_tx_buffer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // receiver: random stalls, none during a burst, stalled throughout while held off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !rx_hold && (burst || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // hold off the receiver long enough for the core to back up into i_in
    initial begin
        rx_hold = 1'b0;
        wait (items_sent >= HOLD_AT);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.tx_valid       = out_ch.tx_valid;
            got.tx_byte        = out_ch.tx_byte;
            got.read_valid     = out_ch.read_valid;
            got.read_byte      = out_ch.read_byte;
            got.write_accepted = out_ch.write_accepted;
            got.tx_irq_on      = out_ch.tx_irq_on;
            got.wakeup         = out_ch.wakeup;
            got.rx_dropped     = out_ch.rx_dropped;
            got.echo_dropped   = out_ch.echo_dropped;
            tracker.match_reply(got);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_event(input logic [1:0] kind, input logic [7:0] value);
        while (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.in_byte <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.take_event(kind, value);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write echo_enable, then read it back
    task automatic apb_set_echo(input bit en);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ECHO_ENABLE_ADDR;
        pwdata  <= 32'(en);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_echo(en);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[0] !== en) begin
            $display("%0t: echo_enable readback mismatch, expected %0h, got %0h",
                     $time, en, prdata[0]);
            tracker.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [1:0] pick_kind(int bias);
        int roll;
        roll = $urandom_range(0, 99);
        case (bias)
            0: begin
                // fill
                if (roll < 40) return KIND_RX_CHAR;
                if (roll < 55) return KIND_TX_READY;
                if (roll < 85) return KIND_SW_WRITE;
                return KIND_SW_READ;
            end
            1: begin
                // drain
                if (roll < 15) return KIND_RX_CHAR;
                if (roll < 55) return KIND_TX_READY;
                if (roll < 65) return KIND_SW_WRITE;
                return KIND_SW_READ;
            end
            default: return 2'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic run_traffic(input int count, input bit with_burst);
        int bias;
        bias = 2;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) bias = $urandom_range(0, 2);
            burst = with_burst && (i < count / 2);
            send_event(pick_kind(bias), 8'($urandom_range(0, 255)));
        end
        burst = 1'b0;
    endtask

    initial begin
        tracker       = new();
        items_sent    = 0;
        burst         = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_RX_CHAR;
        in_ch.in_byte = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // nothing to send with interrupts off, then read from an empty queue
        send_event(KIND_TX_READY, 8'h00);
        send_event(KIND_SW_READ, 8'hFF);
        // fill receive and echo, first echo turns interrupts on, ninth drops both
        for (int k = 0; k < 9; k++)
            send_event(KIND_RX_CHAR, (k == 0) ? 8'h00 : (k == 7) ? 8'hFF :
                       8'($urandom_range(0, 255)));
        // free one echo slot: next char is echoed but lost on receive
        send_event(KIND_TX_READY, 8'hA5);
        send_event(KIND_RX_CHAR, 8'h5A);
        // free one receive slot: next char is kept but its echo is lost
        send_event(KIND_SW_READ, 8'h00);
        send_event(KIND_RX_CHAR, 8'hA5);
        // fill transmit queue, the ninth write is refused
        for (int k = 0; k < 9; k++)
            send_event(KIND_SW_WRITE, (k == 0) ? 8'hFF : (k == 1) ? 8'h00 :
                       8'($urandom_range(0, 255)));
        send_event(KIND_TX_READY, 8'h00);

        wait_drained();
        apb_set_echo(1'b0);
        run_traffic(PHASE_ITEMS, 1'b0);
        wait_drained();
        apb_set_echo(1'b1);
        run_traffic(PHASE_ITEMS, 1'b1);
        wait_drained();
        apb_set_echo(1'b0);
        run_traffic(PHASE_ITEMS, 1'b0);
        wait_drained();
        apb_set_echo(1'b1);
        run_traffic(PHASE_ITEMS, 1'b0);

        in_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
